[rtl/mcte_pkg.sv]
// Shared types, constants and control structs for the timer expiry block.
`timescale 1ns / 1ps
package mcte_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_RES       = 16;
  localparam int RES_W         = $clog2(MAX_RES);
  localparam int TIME_W        = 48;
  localparam int PER_W         = 32;
  localparam int VAL_W         = 32;

  // Function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_ARM    = 2'd1;
  localparam logic [1:0] FUNC_DISARM = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic [3:0]              slot;
    logic signed [VAL_W-1:0] delay;
    logic signed [PER_W-1:0] period;
    logic [VAL_W-1:0]        elapsed;
  } in_t;

  typedef struct packed {
    logic              fired;
    logic [3:0]        fired_slot;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] next_deadline;
    logic              last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // input transfer this cycle
    logic arm;    // apply arm / disarm from held item
    logic scan;   // read next slot, advance scan pointer
    logic emit;   // load next result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_tick;    // incoming item is a tick
    logic last_slot;  // scan pointer sits on the final slot
    logic out_free;   // output register can take a result
    logic emit_last;  // next emitted result is the final one
  } sts_t;

endpackage

[rtl/mcte_ctrl.sv]
// Sequencer: accept, arm/disarm, slot scan, drain and result emission.
`timescale 1ns / 1ps
module mcte_ctrl import mcte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    cmd.start = in_valid && in_ready_r;
    cmd.arm   = (state_r == S_ARM);
    cmd.scan  = (state_r == S_SCAN);
    cmd.emit  = (state_r == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            in_ready_r <= 1'b0;
            state_r    <= sts.in_tick ? S_SCAN : S_ARM;
          end
        end
        S_ARM:   state_r <= S_EMIT;
        S_SCAN: begin
          if (sts.last_slot) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= S_EMIT;
        S_EMIT: begin
          if (sts.out_free && sts.emit_last) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/mcte_dp.sv]
// Datapath: time counter, slot memory, scan stage, fire list and output register.
`timescale 1ns / 1ps
module mcte_dp import mcte_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic out_ready,
  output logic out_valid,
  output out_t out_data
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [PER_W-1:0]  period;
  } ent_t;

  in_t               hold_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] earliest_r;
  logic [NUM_SLOTS-1:0] vld_r;
  ent_t              mem [NUM_SLOTS];
  ent_t              rd_ent_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_ptr_r;
  logic [SLOT_W-1:0] proc_idx_r;
  logic              proc_r;
  logic [3:0]        fire_r [MAX_RES];
  logic [RES_W:0]    fire_cnt_r;
  logic [RES_W-1:0]  emit_ptr_r;
  logic              out_valid_r;
  out_t              out_data_r;

  // Scan stage
  logic [TIME_W-1:0] d;
  logic [PER_W-1:0]  p;
  logic [TIME_W-1:0] reload;
  logic              armed;
  logic              expired;
  logic              periodic;

  // Arm path
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic              positive;
  logic              is_arm;
  logic              is_disarm;
  logic [TIME_W-1:0] arm_dl;
  logic [PER_W-1:0]  arm_per;

  // Memory write port
  logic              we;
  logic [SLOT_W-1:0] wa;
  ent_t              wd;

  always_comb begin
    d        = rd_vld_r ? rd_ent_r.deadline : '0;
    p        = rd_vld_r ? rd_ent_r.period : '0;
    armed    = (d != '0);
    expired  = armed && (d < now_r);
    reload   = d + TIME_W'(p);
    periodic = (p != '0);

    slot_ok   = (9'(hold_r.slot) < 9'(NUM_SLOTS));
    slot_idx  = SLOT_W'(hold_r.slot);
    positive  = !hold_r.delay[VAL_W-1] && (hold_r.delay != '0);
    is_arm    = cmd.arm && (hold_r.func == FUNC_ARM) && slot_ok;
    is_disarm = cmd.arm && (hold_r.func == FUNC_DISARM) && slot_ok;
    arm_dl    = now_r + TIME_W'($unsigned(hold_r.delay));
    arm_per   = hold_r.period[PER_W-1] ? '0 : $unsigned(hold_r.period);

    we = 1'b0;
    wa = proc_idx_r;
    wd = '{deadline: reload, period: p};
    priority if (is_arm && positive) begin
      we = 1'b1;
      wa = slot_idx;
      wd = '{deadline: arm_dl, period: arm_per};
    end else if (proc_r && expired && periodic) begin
      we = 1'b1;
    end
  end

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.scan) begin
      rd_ent_r <= mem[rd_ptr_r];
      rd_vld_r <= vld_r[rd_ptr_r];
    end
  end

  // Valid bits: a cleared bit reads as a disarmed slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (is_arm)    vld_r[slot_idx] <= positive;
      if (is_disarm) vld_r[slot_idx] <= 1'b0;
      if (proc_r && expired && !periodic) vld_r[proc_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) hold_r <= in_data;
    if (cmd.scan) proc_idx_r <= rd_ptr_r;
    if (proc_r && expired && (fire_cnt_r < (RES_W+1)'(MAX_RES)))
      fire_r[fire_cnt_r[RES_W-1:0]] <= 4'(proc_idx_r);
    if (cmd.emit) begin
      out_data_r.fired         <= (fire_cnt_r != '0);
      out_data_r.fired_slot    <= (fire_cnt_r != '0) ? fire_r[emit_ptr_r] : '0;
      out_data_r.now           <= now_r;
      out_data_r.next_deadline <= earliest_r;
      out_data_r.last          <= sts.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      earliest_r  <= '1;
      rd_ptr_r    <= '0;
      proc_r      <= 1'b0;
      fire_cnt_r  <= '0;
      emit_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      proc_r <= cmd.scan;
      if (cmd.start) begin
        rd_ptr_r   <= '0;
        fire_cnt_r <= '0;
        emit_ptr_r <= '0;
        if (in_data.func == FUNC_TICK) begin
          now_r      <= now_r + TIME_W'(in_data.elapsed);
          earliest_r <= '1;
        end
      end
      if (cmd.scan) rd_ptr_r <= rd_ptr_r + SLOT_W'(1);
      if (is_arm && positive && (arm_dl != '0) && (arm_dl < earliest_r))
        earliest_r <= arm_dl;
      if (proc_r) begin
        if (expired) begin
          if (fire_cnt_r < (RES_W+1)'(MAX_RES)) fire_cnt_r <= fire_cnt_r + 1'b1;
          if (periodic && (reload != '0) && (reload < earliest_r))
            earliest_r <= reload;
        end else if (armed && (d < earliest_r)) begin
          earliest_r <= d;
        end
      end
      if (cmd.emit) begin
        emit_ptr_r  <= emit_ptr_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.in_tick   = (in_data.func == FUNC_TICK);
    sts.last_slot = (rd_ptr_r == SLOT_W'(NUM_SLOTS - 1));
    sts.out_free  = !out_valid_r || out_ready;
    sts.emit_last = (fire_cnt_r == '0) ||
                    ({1'b0, emit_ptr_r} == fire_cnt_r - (RES_W+1)'(1));
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/multi_channel_timer_expiry_top.sv]
// Top level of the multi-slot timer table with monotonic time counter.
//
// Usage:
//   in_*  : one item per transfer. func selects tick, arm or disarm. A tick
//           adds elapsed to the 48-bit time and scans every slot; each armed
//           slot whose deadline lies below the new time is reported.
//   out_* : results in order. Arm, disarm and a quiet tick give one result
//           with fired low; a tick gives one result per expired slot (up to
//           16). last marks the final result of an item. All results of one
//           item carry the same now and next_deadline.
// Flow:
//   arm, disarm: the held item is applied in the arm state, then its result
//   is emitted. tick: one slot read per cycle in the scan state, a drain
//   state, then one result per cycle while out_ready does not stall.
//   One item in flight; in_ready returns once the final result is loaded
//   into the output register, so the next item can enter while it waits.
// Reset: rst_n (sync) clears time, marks all slots disarmed via valid bits
//   and sets next deadline to all ones; no clearing pass is needed.
// Stall: out_valid and out_data hold while out_ready is low; the
//   sequencer waits and no result is lost.
`timescale 1ns / 1ps
module multi_channel_timer_expiry_top import mcte_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns the item flow and handshake on the input side
  mcte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: timer state, scan stage and output register
  mcte_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/mcte_chk.sv]
// Port-level checker for the timer expiry top level, with its bind.
`timescale 1ns / 1ps
module mcte_chk import mcte_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Protocol: a stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Protocol: a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One item at a time: the block is busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A non-final transfer is followed at once by another fired result of
  // the same tick with the same time stamp
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.fired && $stable(out_data.now))
    else $error("broken result burst");

endmodule

bind multi_channel_timer_expiry_top mcte_chk u_mcte_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
